[rtl/iqpa_pkg.sv]
// ----------------------------------------------------------------------------
// iqpa_pkg
// Shared constants, types and the arctangent table for the IQ phase unit.
// ----------------------------------------------------------------------------
package iqpa_pkg;

    // Default parameter values
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF   = 16;

    // Output phase width, Q3.13 radians
    localparam int PHASE_W     = 16;
    // Angle accumulator, units of 2^-20 rad
    localparam int ACC_W       = 25;
    // Components are prescaled by 2^8 before the micro-rotations
    localparam int PRESCALE_SH = 8;
    // Headroom for sign flip and CORDIC gain
    localparam int GUARD_W     = 3;
    localparam int ATAN_LEN    = 24;

    localparam int PI_ACC      = 3294199;
    localparam int PI_OUT      = 25736;
    localparam int HALF_PI_OUT = 12868;
    localparam int OUT_SHIFT   = 7;
    localparam int OUT_ROUND   = 64;

    // Sample classification, carried alongside the vector
    typedef struct packed {
        logic re_zero;
        logic im_zero;
        logic re_neg;
        logic im_neg;
    } t_spec;

    // round(atan(2^-idx) * 2^20)
    function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:       v = ACC_W'(823550);
            1:       v = ACC_W'(486170);
            2:       v = ACC_W'(256879);
            3:       v = ACC_W'(130396);
            4:       v = ACC_W'(65451);
            5:       v = ACC_W'(32757);
            6:       v = ACC_W'(16383);
            7:       v = ACC_W'(8192);
            8:       v = ACC_W'(4096);
            9:       v = ACC_W'(2048);
            10:      v = ACC_W'(1024);
            11:      v = ACC_W'(512);
            12:      v = ACC_W'(256);
            13:      v = ACC_W'(128);
            14:      v = ACC_W'(64);
            15:      v = ACC_W'(32);
            16:      v = ACC_W'(16);
            17:      v = ACC_W'(8);
            18:      v = ACC_W'(4);
            19:      v = ACC_W'(2);
            20:      v = ACC_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/iqpa_cordic_stage.sv]
// ----------------------------------------------------------------------------
// iqpa_cordic_stage
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module iqpa_cordic_stage
    import iqpa_pkg::*;
#(
    parameter int XW    = 27,
    parameter int STAGE = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [XW-1:0]    i_x,
    input  logic signed [XW-1:0]    i_y,
    input  logic signed [ACC_W-1:0] i_z,
    input  t_spec                   i_spec,
    output logic                    o_valid,
    output logic signed [XW-1:0]    o_x,
    output logic signed [XW-1:0]    o_y,
    output logic signed [ACC_W-1:0] o_z,
    output t_spec                   o_spec
);

    localparam logic signed [ACC_W-1:0] ANGLE = atan_entry(STAGE);

    logic                    r_valid;
    logic signed [XW-1:0]    r_x, n_x;
    logic signed [XW-1:0]    r_y, n_y;
    logic signed [ACC_W-1:0] r_z, n_z;
    t_spec                   r_spec;

    always_comb begin
        // Rotate toward the x axis; shifts floor like the arithmetic model
        if (!i_y[XW-1]) begin
            n_x = i_x + (i_y >>> STAGE);
            n_y = i_y - (i_x >>> STAGE);
            n_z = i_z + ANGLE;
        end else begin
            n_x = i_x - (i_y >>> STAGE);
            n_y = i_y + (i_x >>> STAGE);
            n_z = i_z - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_spec <= i_spec;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_spec  = r_spec;

endmodule

[rtl/iq_phase_atan2_unit.sv]
// ----------------------------------------------------------------------------
// iq_phase_atan2_unit
// Four-quadrant phase of a complex sample by pipelined CORDIC vectoring.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata: real_part [SW-1:0], imag_part [2*SW-1:SW]
// m_axis    out        tdata: phase_angle [15:0], Q3.13 rad, pi = 25736
//
// One item per cycle while the output is not stalled. Stages: an input stage
// (prescale and half-turn), one stage per micro-rotation, a rounding stage.
// The whole pipeline advances together; a stalled output freezes every
// stage and drops tready. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module iq_phase_atan2_unit
    import iqpa_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int ITERATIONS   = ITERATIONS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    // real_part, imag_part, zero fill
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       i_s_tdata,
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    // phase_angle
    output logic [PHASE_W-1:0]                        o_m_tdata
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int XW = SAMPLE_WIDTH + PRESCALE_SH + GUARD_W;
    localparam int NR = (ITERATIONS < ATAN_LEN) ? ITERATIONS : ATAN_LEN;

    localparam logic signed [ACC_W-1:0] PI_A   = ACC_W'(PI_ACC);
    localparam logic signed [ACC_W:0]   ROUND_A = (ACC_W+1)'(OUT_ROUND);
    localparam logic signed [ACC_W:0]   PI_Q    = (ACC_W+1)'(PI_OUT);
    localparam logic signed [ACC_W:0]   NPI_Q   = -(ACC_W+1)'(PI_OUT);
    localparam logic [PHASE_W-1:0]      PI_P    = PHASE_W'(PI_OUT);
    localparam logic [PHASE_W-1:0]      HPI_P   = PHASE_W'(HALF_PI_OUT);

    logic en;

    // Input stage
    logic signed [SW-1:0]    re, im;
    logic signed [XW-1:0]    x_pre;
    logic signed [XW-1:0]    n_x0, n_y0;
    logic signed [ACC_W-1:0] n_z0;
    t_spec                   n_spec0;

    // Stage registers along the pipeline, index 0 is the input stage
    logic                    v_p [0:NR];
    logic signed [XW-1:0]    x_p [0:NR];
    logic signed [XW-1:0]    y_p [0:NR];
    logic signed [ACC_W-1:0] z_p [0:NR];
    t_spec                   s_p [0:NR];

    logic                    r_v0;
    logic signed [XW-1:0]    r_x0, r_y0;
    logic signed [ACC_W-1:0] r_z0;
    t_spec                   r_spec0;

    // Output stage
    logic signed [ACC_W:0]   sum_r;
    logic signed [ACC_W:0]   q;
    logic [PHASE_W-1:0]      n_phase;
    logic                    r_out_valid;
    logic [PHASE_W-1:0]      r_phase;
    t_spec                   spec_l;

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    assign re = i_s_tdata[SW-1:0];
    assign im = i_s_tdata[2*SW-1:SW];

    always_comb begin
        n_spec0.re_zero = (re == '0);
        n_spec0.im_zero = (im == '0);
        n_spec0.re_neg  = re[SW-1];
        n_spec0.im_neg  = im[SW-1];
        x_pre = {{(XW-SW-PRESCALE_SH){re[SW-1]}}, re, {PRESCALE_SH{1'b0}}};
        // Turn the left half-plane by pi and start the angle there
        if (re[SW-1]) begin
            n_x0 = -x_pre;
            n_y0 = -{{(XW-SW-PRESCALE_SH){im[SW-1]}}, im, {PRESCALE_SH{1'b0}}};
            n_z0 = im[SW-1] ? -PI_A : PI_A;
        end else begin
            n_x0 = x_pre;
            n_y0 = {{(XW-SW-PRESCALE_SH){im[SW-1]}}, im, {PRESCALE_SH{1'b0}}};
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0    <= n_x0;
            r_y0    <= n_y0;
            r_z0    <= n_z0;
            r_spec0 <= n_spec0;
        end
    end

    assign v_p[0] = r_v0;
    assign x_p[0] = r_x0;
    assign y_p[0] = r_y0;
    assign z_p[0] = r_z0;
    assign s_p[0] = r_spec0;

    for (genvar g = 0; g < NR; g++) begin : g_rot
        iqpa_cordic_stage #(
            .XW    (XW),
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_p[g]),
            .i_x     (x_p[g]),
            .i_y     (y_p[g]),
            .i_z     (z_p[g]),
            .i_spec  (s_p[g]),
            .o_valid (v_p[g+1]),
            .o_x     (x_p[g+1]),
            .o_y     (y_p[g+1]),
            .o_z     (z_p[g+1]),
            .o_spec  (s_p[g+1])
        );
    end

    assign spec_l = s_p[NR];

    always_comb begin
        // Round half up to Q3.13, clamp to +/- pi; fixed phase on an axis
        sum_r = {z_p[NR][ACC_W-1], z_p[NR]} + ROUND_A;
        q     = sum_r >>> OUT_SHIFT;
        if (spec_l.re_zero) begin
            if (spec_l.im_neg) begin
                n_phase = -HPI_P;
            end else if (spec_l.im_zero) begin
                n_phase = '0;
            end else begin
                n_phase = HPI_P;
            end
        end else if (spec_l.im_zero) begin
            n_phase = spec_l.re_neg ? PI_P : '0;
        end else if (q > PI_Q) begin
            n_phase = PI_P;
        end else if (q < NPI_Q) begin
            n_phase = -PI_P;
        end else begin
            n_phase = q[PHASE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v_p[NR];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_phase <= n_phase;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_phase;

    // Assertions
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata) <= $signed(PI_P)) &&
                       ($signed(o_m_tdata) >= -$signed(PI_P)))
        else $error("phase outside +/- pi");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !v_p[NR])
        else $error("pipeline holds an item after reset");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_p[NR] && r_out_valid && !i_m_tready) |=> v_p[NR] && $stable(z_p[NR]))
        else $error("last rotation stage moved during a stall");

    a_axis_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && v_p[NR] && spec_l.im_zero && !spec_l.re_zero) |=>
            (o_m_tdata == PI_P) || (o_m_tdata == '0))
        else $error("real-axis sample gave a phase other than 0 or pi");

endmodule

[verif/tb_iq_phase_atan2_unit.sv]
// ----------------------------------------------------------------------------
// tb_iq_phase_atan2_unit
// Self-checking bench for the pipelined CORDIC phase unit. Complex samples
// stream in with random gaps and output stalls. A bit-exact phase predictor
// forms the expected Q3.13 angle of every accepted sample, and each result
// is checked in order against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_iq_phase_atan2_unit;

    localparam int SW          = 16;
    localparam int IN_W        = ((2*SW+7)/8)*8;
    localparam int ROTATIONS   = 16;
    localparam int LATENCY     = ROTATIONS + 2;
    localparam int HOLD_CYCLES = 200;

    // Angle units of 2^-20 rad for the accumulator, Q3.13 on the output
    localparam longint ANGLE_PI    = 3294199;
    localparam longint PHASE_PI    = 25736;
    localparam longint PHASE_HALF  = 12868;
    localparam longint ATAN_Q20 [0:23] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0, 0, 0
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [IN_W-1:0]                i_s_tdata;   // real_part, imag_part
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [iqpa_pkg::PHASE_W-1:0]   o_m_tdata;   // phase_angle

    logic [15:0] phase_expected [$];
    int          mismatch_count;
    bit          tx_gap_en;
    bit          rx_stall_en;
    bit          hold_req;

    iq_phase_atan2_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Four-quadrant phase, bit exact with the fixed-point CORDIC
    function automatic logic [15:0] phase_of_sample(input logic signed [15:0] re,
                                                    input logic signed [15:0] im);
        longint x, y, z, dx, dy, q;
        if (re == 0) begin
            if (im > 0) return PHASE_HALF[15:0];
            if (im < 0) return 16'(-PHASE_HALF);
            return '0;
        end
        if (im == 0)
            return (re < 0) ? PHASE_PI[15:0] : 16'd0;
        x = longint'(re) * 256;
        y = longint'(im) * 256;
        z = 0;
        // turn left half-plane vectors by pi first
        if (re < 0) begin
            x = -x;
            y = -y;
            z = (im >= 0) ? ANGLE_PI : -ANGLE_PI;
        end
        for (int k = 0; k < ROTATIONS && k < 24; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_Q20[k];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_Q20[k];
            end
        end
        q = (z + 64) >>> 7;
        if (q > PHASE_PI)  q = PHASE_PI;
        if (q < -PHASE_PI) q = -PHASE_PI;
        return q[15:0];
    endfunction

    // Zero, full-scale and small values more often than a flat draw gives
    function automatic logic signed [15:0] rand_component();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return 16'sd0;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7fff;
                    1:       return 16'sh8000;
                    2:       return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            2, 3:    return 16'($signed($urandom_range(0, 32)) - 16);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        if (!tx_gap_en) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im);
        int gap;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {im, re};
        do @(posedge i_clk); while (!o_s_tready);
        phase_expected.push_back(phase_of_sample(re, im));
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        // stop offering before waiting so no item goes in twice
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (phase_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_corners();
        logic signed [15:0] re_list [24] = '{
            0, 0, 0, 0, 0, 1, -1, 32767, -32768, 32767, -32768, -32768,
            32767, 1, -1, -1, 1, -1, -32768, -32768, 32767, 32767, 100, -5
        };
        logic signed [15:0] im_list [24] = '{
            0, 1, -1, 32767, -32768, 0, 0, 0, 0, 32767, -32768, 32767,
            -32768, 1, 1, -1, -1, -32768, -1, 1, 1, -1, -300, 7
        };
        for (int k = 0; k < 24; k++)
            send_sample(re_list[k], im_list[k]);
    endtask

    task automatic test_random_stream(input int count);
        // open with a stretch where neither side idles
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        for (int k = 0; k < count; k++) begin
            if (k == count / 4) begin
                tx_gap_en   = 1'b1;
                rx_stall_en = 1'b1;
            end
            send_sample(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic test_output_holdoff(input int count);
        tx_gap_en = 1'b0;
        hold_req  = 1'b1;
        for (int k = 0; k < count; k++)
            send_sample(rand_component(), rand_component());
        tx_gap_en = 1'b1;
    endtask

    task automatic test_pause_until_drained(input int count);
        for (int k = 0; k < count; k++)
            send_sample(rand_component(), rand_component());
        wait_drained();
        for (int k = 0; k < count; k++)
            send_sample(rand_component(), rand_component());
    endtask

    task automatic test_mixed_magnitudes(input int count);
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
        for (int k = 0; k < count; k++)
            send_sample(rand_component(), rand_component());
    endtask

    // Output side: random stalls, or one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else if (rx_stall_en && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 2);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (phase_expected.size() == 0) begin
                $display("%0t: unexpected phase result, actual %0d", $time,
                         $signed(o_m_tdata));
                mismatch_count++;
            end else begin
                want = phase_expected.pop_front();
                if (o_m_tdata !== want) begin
                    $display("%0t: phase_angle mismatch, expected %0d, actual %0d",
                             $time, $signed(want), $signed(o_m_tdata));
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        tx_gap_en      = 1'b0;
        rx_stall_en    = 1'b0;
        hold_req       = 1'b0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_random_stream(400);
        test_output_holdoff(80);
        test_pause_until_drained(30);
        test_mixed_magnitudes(450);

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
